// ===== src/mbpf_pkg.sv =====
// Shared types and constants for the monochrome bitmap to page framebuffer block.
// Holds the panel geometry, the register reset values, the item mode codes and
// the command and status bundles between the controller and the datapath.
package mbpf_pkg;

    localparam int PANEL_WIDTH  = 128;
    localparam int PANEL_PAGES  = 8;
    localparam int PANEL_HEIGHT = 64;

    localparam int STORE_CELLS  = PANEL_WIDTH * PANEL_PAGES;
    localparam int ADDR_W       = $clog2(STORE_CELLS);
    localparam int CELL_W       = 8;

    localparam int CFG_W        = 8;
    localparam int S_TDATA_W    = 24;
    localparam int M_TDATA_W    = 8;

    localparam logic [7:0] WIDTH_RESET  = 8'd128;
    localparam logic [7:0] HEIGHT_RESET = 8'd64;
    localparam logic [7:0] XOFF_RESET   = 8'd0;
    localparam logic [6:0] YOFF_RESET   = 7'd0;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_IMAGE = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_XOFF   = 2'd2,
        REG_YOFF   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic load;
        logic sweep;
        logic pixel;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic pixel_stop;
        logic out_free;
    } dp_status_t;

endpackage

// ===== src/mono_bitmap_to_page_framebuffer_top.sv =====
// Top level of the monochrome bitmap to page framebuffer block.
// Depends on mbpf_pkg, mbpf_ctrl and mbpf_datapath.
//
// Input beats carry a mode in s_axis_tuser: clear the frame store, draw one
// byte of a 1-bit-per-pixel image (eight pixels, LSB first, row-major), or
// read one cell. Every input beat yields exactly one output beat: m_axis_tdata
// holds the cell read (zero for other modes), m_axis_tlast marks the beat
// that finished the last pixel of the image. The user writes registers through
// cfg_we, cfg_index and cfg_data only while the block is idle; the block does
// not enforce this. Each pixel is a read-modify-write of one cell through the
// registered read port of the store; a forwarding register lets pixels go at
// one per cycle. An image beat runs its pixel steps (fewer than eight when the
// image ends inside the byte) and a flush state before its result, a read a
// flush state, an unused mode none, and a clear the one-cell-per-cycle sweep.
// After reset the store is swept to zero; s_axis_tready stays low meanwhile.
// A result waits in the output register while the receiver stalls; the next
// input beat is still taken and worked on up to its result.
module mono_bitmap_to_page_framebuffer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // image_byte[7:0], page[10:8], column[17:11]
    input  logic [1:0]  s_axis_tuser,  // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // read_data[7:0]
    output logic        m_axis_tlast
);
    import mbpf_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    mode_t      s_mode;
    cfg_reg_t   cfg_reg;

    assign s_mode  = mode_t'(s_axis_tuser);
    assign cfg_reg = cfg_reg_t'(cfg_index);

    mbpf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_mode   (s_mode),
        .cmd      (cmd),
        .status   (status)
    );

    mbpf_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_reg),
        .cfg_data  (cfg_data),
        .s_mode    (s_mode),
        .s_tdata   (s_axis_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tdata   (m_axis_tdata),
        .m_tlast   (m_axis_tlast)
    );

endmodule

// ===== src/mbpf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the frame store.
module mbpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/mbpf_datapath.sv =====
// Datapath: configuration registers, source position, pixel read-modify-write
// pipeline with forwarding, clearing sweep and the result register.
// Depends on mbpf_pkg and mbpf_ram.
module mbpf_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  mbpf_pkg::cfg_reg_t            cfg_index,
    input  logic [mbpf_pkg::CFG_W-1:0]    cfg_data,
    input  mbpf_pkg::mode_t               s_mode,
    input  logic [mbpf_pkg::S_TDATA_W-1:0] s_tdata,
    input  mbpf_pkg::dp_cmd_t             cmd,
    output mbpf_pkg::dp_status_t          status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mbpf_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import mbpf_pkg::*;

    logic [7:0] width_reg, height_reg, xoff_reg;
    logic [6:0] yoff_reg;

    mode_t      mode_reg;
    logic [7:0] byte_reg;
    logic [2:0] page_reg;
    logic [6:0] column_reg;

    logic [7:0] pixel_x_reg, pixel_x_next;
    logic [7:0] pixel_y_reg, pixel_y_next;
    logic [2:0] bit_idx_reg;
    logic       done_reg;

    logic [ADDR_W-1:0] clr_addr_reg;

    logic              rmw_valid_reg;
    logic [ADDR_W-1:0] rmw_addr_reg;
    logic [2:0]        rmw_bit_reg;
    logic              rmw_set_reg;
    logic              fwd_hit_reg;
    logic [CELL_W-1:0] fwd_data_reg;

    logic              out_valid_reg;
    logic [CELL_W-1:0] out_data_reg;
    logic              out_last_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [CELL_W-1:0] ram_wdata, ram_rdata;

    logic [9:0]  px, py;
    logic        in_panel;
    logic [16:0] pix_addr_full, rd_addr_full;
    logic        rd_in_range;
    logic [8:0]  nx, ny;
    logic        img_done_now;
    logic [CELL_W-1:0] old_cell, mask;

    // Position of the current source pixel on the panel.
    assign px = {2'b00, pixel_x_reg} + {{2{xoff_reg[7]}}, xoff_reg};
    assign py = {2'b00, pixel_y_reg} + {{3{yoff_reg[6]}}, yoff_reg};
    assign in_panel = !px[9] && (px < 10'(PANEL_WIDTH)) && !py[9] &&
                      (py < 10'(PANEL_HEIGHT)) && ({3'b000, py[9:3]} < 10'(PANEL_PAGES));
    assign pix_addr_full = 17'(py[9:3]) * 17'(PANEL_WIDTH) + 17'(px);

    assign rd_in_range  = ({2'b00, page_reg} < 5'(PANEL_PAGES)) &&
                          ({2'b00, column_reg} < 9'(PANEL_WIDTH));
    assign rd_addr_full = 17'(page_reg) * 17'(PANEL_WIDTH) + 17'(column_reg);

    // Position stepping.
    assign nx = {1'b0, pixel_x_reg} + 9'd1;
    assign ny = {1'b0, pixel_y_reg} + 9'd1;
    always_comb begin
        pixel_x_next = pixel_x_reg;
        pixel_y_next = pixel_y_reg;
        img_done_now = 1'b0;
        if (nx < {1'b0, width_reg}) begin
            pixel_x_next = nx[7:0];
        end else begin
            pixel_x_next = 8'd0;
            if (ny < {1'b0, height_reg}) begin
                pixel_y_next = ny[7:0];
            end else begin
                pixel_y_next = 8'd0;
                img_done_now = 1'b1;
            end
        end
    end

    // Second pipeline stage: merge the pixel into the cell just read.
    assign old_cell = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign mask     = CELL_W'(1) << rmw_bit_reg;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = rmw_addr_reg;
        ram_wdata = rmw_set_reg ? (old_cell | mask) : (old_cell & ~mask);
        if (cmd.sweep) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else if (rmw_valid_reg) begin
            ram_we = 1'b1;
        end
        ram_raddr = cmd.pixel ? ADDR_W'(pix_addr_full) : ADDR_W'(rd_addr_full);
    end

    mbpf_ram #(
        .WIDTH (CELL_W),
        .DEPTH (STORE_CELLS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            xoff_reg   <= XOFF_RESET;
            yoff_reg   <= YOFF_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_XOFF:   xoff_reg   <= cfg_data;
                REG_YOFF:   yoff_reg   <= cfg_data[6:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg   <= s_mode;
            byte_reg   <= s_tdata[7:0];
            page_reg   <= s_tdata[10:8];
            column_reg <= s_tdata[17:11];
            done_reg   <= 1'b0;
        end else if (cmd.pixel && img_done_now) begin
            done_reg <= 1'b1;
        end
        rmw_addr_reg <= ADDR_W'(pix_addr_full);
        rmw_bit_reg  <= py[2:0];
        rmw_set_reg  <= byte_reg[bit_idx_reg];
        fwd_data_reg <= ram_wdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_x_reg   <= 8'd0;
            pixel_y_reg   <= 8'd0;
            bit_idx_reg   <= 3'd0;
            clr_addr_reg  <= '0;
            rmw_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end else begin
            rmw_valid_reg <= cmd.pixel && in_panel;
            fwd_hit_reg   <= ram_we && (ram_waddr == ram_raddr);
            if (cmd.load) begin
                bit_idx_reg <= 3'd0;
                if (s_mode == MODE_CLEAR) begin
                    pixel_x_reg <= 8'd0;
                    pixel_y_reg <= 8'd0;
                end
            end else if (cmd.pixel) begin
                bit_idx_reg <= bit_idx_reg + 3'd1;
                pixel_x_reg <= pixel_x_next;
                pixel_y_reg <= pixel_y_next;
            end
            if (cmd.sweep) begin
                clr_addr_reg <= status.sweep_last ? '0 : clr_addr_reg + ADDR_W'(1);
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_data_reg <= (mode_reg == MODE_READ && rd_in_range) ? ram_rdata : '0;
            out_last_reg <= done_reg;
        end
    end

    assign status.sweep_last = (clr_addr_reg == ADDR_W'(STORE_CELLS - 1));
    assign status.pixel_stop = (bit_idx_reg == 3'd7) || img_done_now;
    assign status.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== src/mbpf_ctrl.sv =====
// Controller state machine: sequences the clearing sweep, up to eight pixel
// steps of an image beat, the store read and the result hand-off.
// Depends on mbpf_pkg.
module mbpf_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  mbpf_pkg::mode_t      s_mode,
    output mbpf_pkg::dp_cmd_t    cmd,
    input  mbpf_pkg::dp_status_t status
);
    import mbpf_pkg::*;

    typedef enum logic [4:0] {
        S_SWEEP = 5'b00001,
        S_IDLE  = 5'b00010,
        S_PIXEL = 5'b00100,
        S_FLUSH = 5'b01000,
        S_DONE  = 5'b10000
    } ctl_state_t;

    ctl_state_t state_reg, state_next;
    logic       clr_resp_reg, clr_resp_next;
    logic       accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next    = state_reg;
        clr_resp_next = clr_resp_reg;
        cmd           = '0;
        unique case (state_reg)
            S_SWEEP: begin
                cmd.sweep = 1'b1;
                if (status.sweep_last) begin
                    state_next    = clr_resp_reg ? S_DONE : S_IDLE;
                    clr_resp_next = 1'b0;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    cmd.load = 1'b1;
                    unique case (s_mode)
                        MODE_CLEAR: begin
                            state_next    = S_SWEEP;
                            clr_resp_next = 1'b1;
                        end
                        MODE_IMAGE: state_next = S_PIXEL;
                        MODE_READ:  state_next = S_FLUSH;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_PIXEL: begin
                cmd.pixel = 1'b1;
                if (status.pixel_stop) begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_SWEEP;
            clr_resp_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_resp_reg <= clr_resp_next;
        end
    end

endmodule

// ===== verif/tb_mono_bitmap_to_page_framebuffer_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for mono_bitmap_to_page_framebuffer_top, using mbpf_pkg.
// Streams clear, image and read beats under several geometries and offsets, and
// checks every result beat against an in-bench shadow of the page framebuffer.
module tb_mono_bitmap_to_page_framebuffer_top;
    import mbpf_pkg::*;

    localparam int STALL_LIMIT = 6000;
    localparam int PHASES      = 10;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] image_byte;
        logic [2:0] page;
        logic [6:0] column;
    } beat_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       image_done;
    } cell_result_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [1:0]  cfg_index     = REG_WIDTH;
    logic [7:0]  cfg_data      = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = 24'd0;
    logic [1:0]  s_axis_tuser  = MODE_NONE;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    // Shadow of the frame store, the source position and the registers.
    logic [7:0]        shadow_fb [STORE_CELLS];
    logic [7:0]        src_x;
    logic [7:0]        src_y;
    logic [7:0]        img_w;
    logic [7:0]        img_h;
    logic signed [7:0] x_off;
    logic signed [6:0] y_off;

    beat_t        beat_q[$];
    cell_result_t cell_results_q[$];
    beat_t        taken;
    beat_t        upcoming;
    cell_result_t want_res;
    logic         steady        = 1'b0;
    int           mismatch_count = 0;
    int           idle_cycles    = 0;

    int ph_w  [PHASES] = '{8, 1, 255, 16, 0, 200, 20, 5, 128, 7};
    int ph_h  [PHASES] = '{8, 1, 255, 12, 3, 70, 9, 7, 64, 0};
    int ph_xo [PHASES] = '{0, 127, -128, -5, 10, 100, 120, 3, 0, -1};
    int ph_yo [PHASES] = '{0, 63, -64, -3, 10, 60, -2, 5, 0, 62};
    int ph_n  [PHASES] = '{150, 80, 80, 200, 40, 100, 150, 200, 180, 40};

    mono_bitmap_to_page_framebuffer_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic beat_t make_beat(mode_t mode, logic [7:0] pixels, logic [2:0] page,
                                         logic [6:0] column);
        beat_t b;
        b.mode       = mode;
        b.image_byte = pixels;
        b.page       = page;
        b.column     = column;
        return b;
    endfunction

    // Blits one beat into the shadow store and returns the cell result it yields.
    function automatic cell_result_t blit_beat(beat_t b);
        cell_result_t r;
        int px;
        int py;
        int idx;
        r = '0;
        case (b.mode)
            MODE_CLEAR: begin
                for (int i = 0; i < STORE_CELLS; i++) shadow_fb[i] = 8'd0;
                src_x = 8'd0;
                src_y = 8'd0;
            end
            MODE_IMAGE: begin
                for (int k = 0; k < 8 && !r.image_done; k++) begin
                    px = int'(src_x) + int'(x_off);
                    py = int'(src_y) + int'(y_off);
                    if (px >= 0 && px < PANEL_WIDTH && py >= 0 && py < PANEL_HEIGHT &&
                        (py >> 3) < PANEL_PAGES) begin
                        idx = (py >> 3) * PANEL_WIDTH + px;
                        shadow_fb[idx][py & 7] = b.image_byte[k];
                    end
                    if (int'(src_x) + 1 < int'(img_w)) begin
                        src_x = src_x + 8'd1;
                    end else begin
                        src_x = 8'd0;
                        if (int'(src_y) + 1 < int'(img_h)) begin
                            src_y = src_y + 8'd1;
                        end else begin
                            src_y = 8'd0;
                            r.image_done = 1'b1;
                        end
                    end
                end
            end
            MODE_READ: begin
                if (int'(b.page) < PANEL_PAGES && int'(b.column) < PANEL_WIDTH) begin
                    r.read_data = shadow_fb[int'(b.page) * PANEL_WIDTH + int'(b.column)];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic beat_t random_beat();
        beat_t b;
        int roll;
        roll         = $urandom_range(0, 99);
        b.image_byte = 8'($urandom);
        b.page       = 3'($urandom);
        b.column     = 7'($urandom);
        if (roll < 78) begin
            b.mode = MODE_IMAGE;
        end else if (roll < 92) begin
            b.mode = MODE_READ;
            if ($urandom_range(0, 1) == 1) begin
                b.column = 7'(int'(x_off) + int'($urandom_range(0, 23)));
                b.page   = 3'((int'(y_off) + int'($urandom_range(0, 23))) >>> 3);
            end
        end else if (roll < 97) begin
            b.mode = MODE_CLEAR;
        end else begin
            b.mode = MODE_NONE;
        end
        return b;
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [7:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_WIDTH:  img_w = value;
            REG_HEIGHT: img_h = value;
            REG_XOFF:   x_off = value;
            default:    y_off = value[6:0];
        endcase
    endtask

    task automatic set_geometry(int w, int h, int xo, int yo);
        write_reg(REG_WIDTH, 8'(w));
        write_reg(REG_HEIGHT, 8'(h));
        write_reg(REG_XOFF, 8'(xo));
        write_reg(REG_YOFF, 8'(yo));
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every queued beat has gone and every result is back.
    task automatic wait_idle();
        while (beat_q.size() != 0 || s_axis_tvalid || cell_results_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (16) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                taken.mode       = mode_t'(s_axis_tuser);
                taken.image_byte = s_axis_tdata[7:0];
                taken.page       = s_axis_tdata[10:8];
                taken.column     = s_axis_tdata[17:11];
                cell_results_q.push_back(blit_beat(taken));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (beat_q.size() != 0 && (steady || $urandom_range(0, 99) >= 18)) begin
                    upcoming = beat_q.pop_front();
                    s_axis_tdata  <= {6'd0, upcoming.column, upcoming.page, upcoming.image_byte};
                    s_axis_tuser  <= upcoming.mode;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady || ($urandom_range(0, 99) >= 18);
            if (m_axis_tvalid && m_axis_tready) begin
                if (cell_results_q.size() == 0) begin
                    $error("result beat with no expectation: read_data %0h image_done %0b",
                           m_axis_tdata, m_axis_tlast);
                    mismatch_count++;
                end else begin
                    want_res = cell_results_q.pop_front();
                    if (m_axis_tdata !== want_res.read_data) begin
                        $error("read_data expected %0h actual %0h",
                               want_res.read_data, m_axis_tdata);
                        mismatch_count++;
                    end
                    if (m_axis_tlast !== want_res.image_done) begin
                        $error("image_done expected %0b actual %0b",
                               want_res.image_done, m_axis_tlast);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (beat_q.size() == 0 && !s_axis_tvalid && cell_results_q.size() == 0)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < STORE_CELLS; i++) shadow_fb[i] = 8'd0;
        src_x = 8'd0;
        src_y = 8'd0;
        img_w = WIDTH_RESET;
        img_h = HEIGHT_RESET;
        x_off = XOFF_RESET;
        y_off = YOFF_RESET;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset geometry: a few bytes on the first row, read back, stray fields, a clear.
        beat_q.push_back(make_beat(MODE_READ, 8'h00, 3'd0, 7'd0));
        beat_q.push_back(make_beat(MODE_READ, 8'h00, 3'd7, 7'd127));
        beat_q.push_back(make_beat(MODE_IMAGE, 8'hFF, 3'd0, 7'd0));
        beat_q.push_back(make_beat(MODE_IMAGE, 8'h00, 3'd0, 7'd0));
        beat_q.push_back(make_beat(MODE_IMAGE, 8'hA5, 3'd0, 7'd0));
        beat_q.push_back(make_beat(MODE_READ, 8'h00, 3'd0, 7'd0));
        beat_q.push_back(make_beat(MODE_READ, 8'h00, 3'd0, 7'd8));
        beat_q.push_back(make_beat(MODE_READ, 8'hFF, 3'd0, 7'd16));
        beat_q.push_back(make_beat(MODE_READ, 8'h00, 3'd0, 7'd18));
        beat_q.push_back(make_beat(MODE_NONE, 8'hFF, 3'd7, 7'd127));
        beat_q.push_back(make_beat(MODE_CLEAR, 8'hFF, 3'd7, 7'd127));
        beat_q.push_back(make_beat(MODE_READ, 8'h00, 3'd0, 7'd0));
        beat_q.push_back(make_beat(MODE_IMAGE, 8'h00, 3'd7, 7'd127));
        wait_idle();

        // A tiny image entered with the position past its width; the image ends mid-byte.
        set_geometry(3, 2, 0, 0);
        beat_q.push_back(make_beat(MODE_IMAGE, 8'hFF, 3'd0, 7'd0));
        beat_q.push_back(make_beat(MODE_IMAGE, 8'h3F, 3'd0, 7'd0));
        beat_q.push_back(make_beat(MODE_READ, 8'h00, 3'd0, 7'd0));
        beat_q.push_back(make_beat(MODE_READ, 8'h00, 3'd0, 7'd2));
        beat_q.push_back(make_beat(MODE_READ, 8'h00, 3'd0, 7'd8));
        wait_idle();

        // One-pixel image pushed to the far corner of the panel.
        set_geometry(1, 1, 127, 63);
        beat_q.push_back(make_beat(MODE_IMAGE, 8'hFF, 3'd0, 7'd0));
        beat_q.push_back(make_beat(MODE_READ, 8'h00, 3'd7, 7'd127));
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            set_geometry(ph_w[p], ph_h[p], ph_xo[p], ph_yo[p]);
            steady = (p == 7);
            for (int n = 0; n < ph_n[p]; n++) beat_q.push_back(random_beat());
            wait_idle();
        end
        steady = 1'b0;

        repeat (32) @(posedge aclk);
        if (mismatch_count == 0 && cell_results_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
